### rtl/core/hsvrgb_pkg.sv
// types, constants and stage controls shared by the hsv to rgb converter
`timescale 1ns / 1ps

package hsvrgb_pkg;

	localparam int unsigned HUE_FULL    = 5760;
	localparam int unsigned HUE_SECTOR  = 960;
	localparam int unsigned FULL_SCALE  = 255;
	localparam int unsigned DEN         = FULL_SCALE * HUE_SECTOR;

	localparam int unsigned HUE_W   = 13;
	localparam int unsigned FRAC_W  = 10;
	localparam int unsigned PROD_W  = 18;
	localparam int unsigned X_W     = 26;

	// reciprocal of DEN; the quotient estimate is at most one low
	localparam int unsigned RECIP_SHIFT = 26;
	localparam int unsigned RECIP       = (1 << RECIP_SHIFT) / DEN;
	localparam int unsigned RECIP_W     = 9;
	localparam int unsigned MQ_W        = X_W + RECIP_W;

	typedef struct packed {
		logic [15:0] hue;
		logic        hue_undefined;
		logic [7:0]  saturation;
		logic [7:0]  brightness;
	} hsv_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef enum logic [2:0] {
		SEC_RED_YEL = 3'd0,
		SEC_YEL_GRN = 3'd1,
		SEC_GRN_CYN = 3'd2,
		SEC_CYN_BLU = 3'd3,
		SEC_BLU_MAG = 3'd4,
		SEC_MAG_RED = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t    sector;
		logic       sat_zero;
		logic       hue_undefined;
		logic [7:0] brightness;
	} side_t;

	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
		logic en_s6;
	} pipe_en_t;

endpackage

### rtl/core/hsv_to_rgb_converter_top.sv
// top level of the hsv to rgb pixel converter
`timescale 1ns / 1ps

// Converts one HSV pixel per clock to 8-bit RGB while rgb is not stalled.
// Six register stages: out-of-range hue to zero and sector split, products
// with saturation, numerators over 255*960, reciprocal multiply, quotient
// check product, then correction, sector ordering and the output register.
// An accepted word shows on rgb once it reaches the output register;
// throughput is one word per cycle while rgb is not stalled. Each stage
// holds when it is full and the stage after it cannot load, so empty stages
// are filled even while the output waits. hsv_stall only rises when rgb is
// valid and stalled and every stage ahead is full.

module hsv_to_rgb_converter_top import hsvrgb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic hsv_valid,
	output logic hsv_stall,
	input  hsv_t hsv,
	output logic rgb_valid,
	input  logic rgb_stall,
	output rgb_t rgb
);

	logic [5:0]        vld_q;
	logic [6:0]        ready;
	pipe_en_t          en;
	side_t             side_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic [7:0]        sat_s1;
	logic [X_W-1:0]    xp_s3;
	logic [X_W-1:0]    xq_s3;
	logic [X_W-1:0]    xt_s3;
	logic [7:0]        p;
	logic [7:0]        q;
	logic [7:0]        t;

	// ready[i] means stage i+1 may load this cycle
	always_comb begin
		ready[6] = 1'b0;
		ready[5] = !vld_q[5] || !rgb_stall;
		for (int i = 4; i >= 0; i--) begin
			ready[i] = !vld_q[i] || ready[i+1];
		end
	end

	assign en.en_s1 = ready[0];
	assign en.en_s2 = ready[1];
	assign en.en_s3 = ready[2];
	assign en.en_s4 = ready[3];
	assign en.en_s5 = ready[4];
	assign en.en_s6 = ready[5];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ready[0]) begin
				vld_q[0] <= hsv_valid;
			end
			for (int i = 1; i < 6; i++) begin
				if (ready[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign hsv_stall = !ready[0] || ready[6];
	assign rgb_valid = vld_q[5];

	hsvrgb_sector u_sector (
		.clk     (clk),
		.en      (en),
		.hsv     (hsv),
		.side_s1 (side_s1),
		.frac_s1 (frac_s1),
		.sat_s1  (sat_s1)
	);

	hsvrgb_levels u_levels (
		.clk     (clk),
		.en      (en),
		.side_s1 (side_s1),
		.frac_s1 (frac_s1),
		.sat_s1  (sat_s1),
		.xp_s3   (xp_s3),
		.xq_s3   (xq_s3),
		.xt_s3   (xt_s3)
	);

	hsvrgb_div u_div_p (
		.clk   (clk),
		.en    (en),
		.x_s3  (xp_s3),
		.level (p)
	);

	hsvrgb_div u_div_q (
		.clk   (clk),
		.en    (en),
		.x_s3  (xq_s3),
		.level (q)
	);

	hsvrgb_div u_div_t (
		.clk   (clk),
		.en    (en),
		.x_s3  (xt_s3),
		.level (t)
	);

	hsvrgb_select u_select (
		.clk     (clk),
		.en      (en),
		.side_s1 (side_s1),
		.p       (p),
		.q       (q),
		.t       (t),
		.rgb_s6  (rgb)
	);

endmodule

### rtl/core/hsvrgb_sector.sv
// stage 1: out-of-range hue to zero, sector and fraction within the sector
`timescale 1ns / 1ps

module hsvrgb_sector import hsvrgb_pkg::*; (
	input  logic              clk,
	input  pipe_en_t          en,
	input  hsv_t              hsv,
	output side_t             side_s1,
	output logic [FRAC_W-1:0] frac_s1,
	output logic [7:0]        sat_s1
);

	logic [HUE_W-1:0] hue_w;
	logic [HUE_W-1:0] base;
	sector_t          sector;

	always_comb begin
		hue_w = (hsv.hue >= 16'(HUE_FULL)) ? '0 : hsv.hue[HUE_W-1:0];
		if (hue_w >= HUE_W'(5 * HUE_SECTOR)) begin
			sector = SEC_MAG_RED;
			base   = HUE_W'(5 * HUE_SECTOR);
		end else if (hue_w >= HUE_W'(4 * HUE_SECTOR)) begin
			sector = SEC_BLU_MAG;
			base   = HUE_W'(4 * HUE_SECTOR);
		end else if (hue_w >= HUE_W'(3 * HUE_SECTOR)) begin
			sector = SEC_CYN_BLU;
			base   = HUE_W'(3 * HUE_SECTOR);
		end else if (hue_w >= HUE_W'(2 * HUE_SECTOR)) begin
			sector = SEC_GRN_CYN;
			base   = HUE_W'(2 * HUE_SECTOR);
		end else if (hue_w >= HUE_W'(HUE_SECTOR)) begin
			sector = SEC_YEL_GRN;
			base   = HUE_W'(HUE_SECTOR);
		end else begin
			sector = SEC_RED_YEL;
			base   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			side_s1.sector        <= sector;
			side_s1.sat_zero      <= (hsv.saturation == 8'd0);
			side_s1.hue_undefined <= hsv.hue_undefined;
			side_s1.brightness    <= hsv.brightness;
			frac_s1               <= FRAC_W'(hue_w - base);
			sat_s1                <= hsv.saturation;
		end
	end

endmodule

### rtl/core/hsvrgb_levels.sv
// stages 2 and 3: numerators of p, q and t scaled to the common denominator
`timescale 1ns / 1ps

module hsvrgb_levels import hsvrgb_pkg::*; (
	input  logic              clk,
	input  pipe_en_t          en,
	input  side_t             side_s1,
	input  logic [FRAC_W-1:0] frac_s1,
	input  logic [7:0]        sat_s1,
	output logic [X_W-1:0]    xp_s3,
	output logic [X_W-1:0]    xq_s3,
	output logic [X_W-1:0]    xt_s3
);

	logic [PROD_W-1:0] sf_s2;
	logic [PROD_W-1:0] sft_s2;
	logic [15:0]       pv_s2;
	logic [7:0]        v_s2;
	logic [FRAC_W:0]   frac_rest;

	assign frac_rest = (FRAC_W + 1)'(HUE_SECTOR) - {1'b0, frac_s1};

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			sf_s2  <= PROD_W'(sat_s1) * PROD_W'(frac_s1);
			sft_s2 <= PROD_W'(sat_s1) * PROD_W'(frac_rest);
			pv_s2  <= 16'(side_s1.brightness) * 16'(8'(FULL_SCALE) - sat_s1);
			v_s2   <= side_s1.brightness;
		end
	end

	// p is brought onto the same denominator as q and t
	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			xp_s3 <= X_W'(pv_s2) * X_W'(HUE_SECTOR);
			xq_s3 <= X_W'(v_s2) * X_W'(PROD_W'(DEN) - sf_s2);
			xt_s3 <= X_W'(v_s2) * X_W'(PROD_W'(DEN) - sft_s2);
		end
	end

endmodule

### rtl/core/hsvrgb_div.sv
// stages 4 and 5: truncating division by 255*960 via reciprocal and one correction
`timescale 1ns / 1ps

module hsvrgb_div import hsvrgb_pkg::*; (
	input  logic           clk,
	input  pipe_en_t       en,
	input  logic [X_W-1:0] x_s3,
	output logic [7:0]     level
);

	logic [X_W-1:0]  x_s4;
	logic [MQ_W-1:0] mq_s4;
	logic [X_W-1:0]  x_s5;
	logic [7:0]      q0_s5;
	logic [X_W-1:0]  prod_s5;
	logic [7:0]      q0_w;
	logic [X_W-1:0]  rem;

	assign q0_w = mq_s4[RECIP_SHIFT +: 8];

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			x_s4  <= x_s3;
			mq_s4 <= MQ_W'(x_s3) * MQ_W'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s5) begin
			x_s5    <= x_s4;
			q0_s5   <= q0_w;
			prod_s5 <= X_W'(q0_w) * X_W'(DEN);
		end
	end

	// estimate is never high, so one step up at most
	assign rem   = x_s5 - prod_s5;
	assign level = q0_s5 + 8'(rem >= X_W'(DEN));

endmodule

### rtl/core/hsvrgb_select.sv
// side info delay line and stage 6: sector ordering and gray/black override
`timescale 1ns / 1ps

module hsvrgb_select import hsvrgb_pkg::*; (
	input  logic       clk,
	input  pipe_en_t   en,
	input  side_t      side_s1,
	input  logic [7:0] p,
	input  logic [7:0] q,
	input  logic [7:0] t,
	output rgb_t       rgb_s6
);

	side_t side_s2;
	side_t side_s3;
	side_t side_s4;
	side_t side_s5;
	rgb_t  rgb_w;
	logic [7:0] v;
	logic [7:0] gray;

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			side_s2 <= side_s1;
		end
		if (en.en_s3) begin
			side_s3 <= side_s2;
		end
		if (en.en_s4) begin
			side_s4 <= side_s3;
		end
		if (en.en_s5) begin
			side_s5 <= side_s4;
		end
	end

	assign v    = side_s5.brightness;
	assign gray = side_s5.hue_undefined ? v : 8'd0;

	always_comb begin
		case (side_s5.sector)
			SEC_RED_YEL: rgb_w = '{red: v, green: t, blue: p};
			SEC_YEL_GRN: rgb_w = '{red: q, green: v, blue: p};
			SEC_GRN_CYN: rgb_w = '{red: p, green: v, blue: t};
			SEC_CYN_BLU: rgb_w = '{red: p, green: q, blue: v};
			SEC_BLU_MAG: rgb_w = '{red: t, green: p, blue: v};
			default:     rgb_w = '{red: v, green: p, blue: q};
		endcase
		if (side_s5.sat_zero) begin
			rgb_w = '{red: gray, green: gray, blue: gray};
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s6) begin
			rgb_s6 <= rgb_w;
		end
	end

endmodule

### rtl/core/hsvrgb_checker.sv
// port-level checks for the hsv to rgb converter, bound to the top level
`timescale 1ns / 1ps

module hsvrgb_checker import hsvrgb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic hsv_valid,
	input logic hsv_stall,
	input hsv_t hsv,
	input logic rgb_valid,
	input logic rgb_stall,
	input rgb_t rgb
);

	logic take_black;
	logic take_gray;

	assign take_black = hsv_valid && !hsv_stall && (hsv.saturation == 8'd0)
		&& !hsv.hue_undefined;
	assign take_gray  = hsv_valid && !hsv_stall && (hsv.saturation == 8'd0)
		&& hsv.hue_undefined;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rgb_valid && rgb_stall |=> rgb_valid && $stable(rgb))
		else $error("rgb word changed while stalled");

	// input backpressure only comes from a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> rgb_valid && rgb_stall)
		else $error("input stalled without output stall");

	// zero saturation with defined hue shows black if the output is not stalled meanwhile
	a_black: assert property (@(posedge clk) disable iff (!arst_n)
		take_black ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
		##1 !rgb_stall |=> rgb_valid && (rgb == '0))
		else $error("zero saturation did not give black");

	// zero saturation with undefined hue shows gray at the value level
	a_gray: assert property (@(posedge clk) disable iff (!arst_n)
		take_gray ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall ##1 !rgb_stall
		##1 !rgb_stall |=> rgb_valid && (rgb.red == $past(hsv.brightness, 6))
		&& (rgb.green == rgb.red) && (rgb.blue == rgb.red))
		else $error("zero saturation did not give gray");

endmodule

bind hsv_to_rgb_converter_top hsvrgb_checker u_hsvrgb_checker (.*);
